/* rtl/core/ssi_pkg.sv */
// Package for the stretch source index block: field widths and parameter defaults.
// Used by stretch_source_index and ssi_checker; depends on nothing.
package ssi_pkg;

	localparam int unsigned MAX_LEN_DEFAULT = 4096;

	// Widths of the request and result fields.
	localparam int unsigned LEN_W = 13;
	localparam int unsigned POS_W = 12;
	localparam int unsigned OUT_W = 13;

	// The source counter can run a little past the longest length.
	localparam int unsigned IDX_W = 15;

	// The error term lies within three lengths either side of zero.
	localparam int unsigned ERR_W = 16;

endpackage

/* rtl/core/stretch_source_index.sv */
// Stretch blit source index: Bresenham error walk over one shared adder.
// Depends on ssi_pkg for widths and the default length limit.

// Usage:
// A request on the input channel (in_valid/in_ready) carries dest_length,
// source_length and dest_position. The block answers with one result on the
// output channel (out_valid/out_ready): source_index, the source pixel or row
// that a nearest-neighbor stretch samples at dest_position.
// Lengths of zero count as one, and lengths above MAX_LEN count as MAX_LEN.
// Equal lengths pass the position through unchanged.
// The block holds one request at a time. in_ready is high only while idle.
// The lengths are clamped as the request is taken, and the cycle after
// acceptance sets up the steps and the initial error.
// Then a single error adder runs once per cycle, one destination element or
// one skipped source element per step. Equal lengths go from setup straight
// to the result; otherwise the walk covers up to dest_position destination
// elements, plus the skipped source elements when shrinking.
// The result sits in an output register until out_ready takes it. While the
// receiver stalls, the block keeps the result and stays busy. The next
// request is taken in the cycle after the result leaves.
// Reset returns the sequencer to idle and drops out_valid. No state carries
// from one request to the next.
module stretch_source_index
	import ssi_pkg::*;
#(
	parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [LEN_W-1:0] dest_length,
	input  logic [LEN_W-1:0] source_length,
	input  logic [POS_W-1:0] dest_position,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] source_index
);

	// Largest length after clamping; a limit beyond the field width never clamps.
	localparam logic [LEN_W-1:0] LEN_CAP =
		(MAX_LEN >= (2 ** LEN_W)) ? '1 : LEN_W'(MAX_LEN);

	// Sequencer codes.
	localparam logic [2:0] ST_IDLE = 3'd0; // waiting for a request
	localparam logic [2:0] ST_INIT = 3'd1; // load steps and initial error
	localparam logic [2:0] ST_PRE  = 3'd2; // shrink: skip leading source elements
	localparam logic [2:0] ST_MAIN = 3'd3; // one destination element per step
	localparam logic [2:0] ST_SKIP = 3'd4; // shrink: skip source while error < 0
	localparam logic [2:0] ST_DONE = 3'd5; // result waits for the receiver

	logic [2:0]              state_q;
	logic [LEN_W-1:0]        dl_q;
	logic [LEN_W-1:0]        sl_q;
	logic [POS_W-1:0]        pos_q;
	logic [LEN_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [ERR_W-1:0] minor_q;
	logic signed [ERR_W-1:0] major_q;
	logic                    shrink_q;
	logic [OUT_W-1:0]        result_q;

	logic [LEN_W-1:0]        dl_clamped;
	logic [LEN_W-1:0]        sl_clamped;
	logic [LEN_W-1:0]        len_lo;
	logic [LEN_W-1:0]        len_hi;
	logic signed [ERR_W-1:0] err_next;
	logic                    err_neg;
	logic                    walk_end;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
		logic [LEN_W-1:0] v;
		v = raw;
		if (raw == '0) begin
			v = LEN_W'(1);
		end else if (raw > LEN_CAP) begin
			v = LEN_CAP;
		end
		return v;
	endfunction

	function automatic logic signed [ERR_W-1:0] ext(input logic [LEN_W-1:0] v);
		return signed'({{(ERR_W - LEN_W){1'b0}}, v});
	endfunction

	assign dl_clamped = clamp_len(dest_length);
	assign sl_clamped = clamp_len(source_length);

	// The shorter length sets the minor step, the difference sets the major step.
	assign len_lo = (dl_q < sl_q) ? dl_q : sl_q;
	assign len_hi = (dl_q < sl_q) ? sl_q : dl_q;

	// The one shared adder: a negative error takes the minor step, else the major.
	assign err_neg  = err_q[ERR_W-1];
	assign err_next = err_q + (err_neg ? minor_q : major_q);

	// The walk stops at the queried position, or after the last destination element.
	assign walk_end = (cnt_q == LEN_W'(pos_q)) || (cnt_q == dl_q);

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_DONE);
	assign source_index = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (dl_q == sl_q) begin
						state_q <= ST_DONE;
					end else if (dl_q > sl_q) begin
						state_q <= ST_MAIN;
					end else begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					if (!err_neg) begin
						state_q <= ST_MAIN;
					end
				end
				ST_MAIN: begin
					if (walk_end) begin
						state_q <= ST_DONE;
					end else if (shrink_q) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (!err_neg) begin
						state_q <= ST_MAIN;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; only the sequencer needs a reset.
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_IDLE: begin
				dl_q  <= dl_clamped;
				sl_q  <= sl_clamped;
				pos_q <= dest_position;
			end
			ST_INIT: begin
				cnt_q    <= '0;
				idx_q    <= '0;
				shrink_q <= (dl_q < sl_q);
				minor_q  <= ext(len_lo) <<< 1;
				major_q  <= (ext(len_lo) - ext(len_hi)) <<< 1;
				if (dl_q > sl_q) begin
					err_q <= ext(sl_q) + (ext(sl_q) <<< 1) - (ext(dl_q) <<< 1);
				end else begin
					err_q <= (ext(dl_q) <<< 1) - ext(sl_q);
				end
				result_q <= OUT_W'(pos_q);
			end
			ST_PRE, ST_SKIP: begin
				err_q <= err_next;
				if (err_neg) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			ST_MAIN: begin
				if (walk_end) begin
					result_q <= idx_q[OUT_W-1:0];
				end else begin
					cnt_q <= cnt_q + LEN_W'(1);
					if (shrink_q) begin
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						err_q <= err_next;
						if (!err_neg) begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/ssi_checker.sv */
// Port-level checks for stretch_source_index, attached by the bind below.
// Depends on ssi_pkg for the result width.
module ssi_checker
	import ssi_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] source_index
);

	// One request at a time: the block never takes a request while holding a result.
	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("in_ready high while a result is pending");

	// A result never appears in the cycle right after a request is taken.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result shown in the cycle after acceptance");

	// Handing off the result frees the block at once.
	a_free_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> (in_ready && !out_valid))
		else $error("block not idle after result was taken");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(source_index)))
		else $error("result changed or dropped while stalled");

endmodule

bind stretch_source_index ssi_checker u_ssi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.source_index (source_index)
);
